[design/bpfa_pkg.sv]
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = MAX_FRAMES / WORD_BITS;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int FRAME_W    = ADDR_W + BIT_W;
  localparam int COUNT_W    = 17;
  localparam int FLIP_W     = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t ALL_ONES = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAMES);

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_RESERVE = 3'd3;
  localparam logic [2:0] OP_INIT    = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOMEM = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [FRAME_W-1:0] lo;
    logic [FRAME_W-1:0] hi;
    logic               set_bits;
  } span_t;

  typedef struct packed {
    word_t             new_word;
    logic [FLIP_W-1:0] flips;
    logic              found;
    logic [BIT_W-1:0]  found_bit;
    word_t             alloc_word;
  } word_res_t;

  function automatic logic [FLIP_W-1:0] popcount(input word_t w);
    logic [2:0]        grp;
    logic [FLIP_W-1:0] sum;
    sum = '0;
    for (int g = 0; g < WORD_BITS / 4; g++) begin
      grp = 3'(w[4*g]) + 3'(w[4*g+1]) + 3'(w[4*g+2]) + 3'(w[4*g+3]);
      sum = sum + FLIP_W'(grp);
    end
    return sum;
  endfunction

  function automatic logic [BIT_W-1:0] bit_index(input word_t onehot);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[design/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    operation, frame_number, frame_count
// out       out_valid / out_stall  status, allocated_frame, used_count, free_count
// cfg       cfg_write              cfg_data (total_frames)
//
// An item visits bitmap words one at a time, as the single
// bitmap memory is read and written back one word per cycle: allocate visits words up
// to the first one with a free frame, a region one visits its span and then word zero,
// and initialize visits every managed word, up to 2048 words.
// After reset a clearing pass sets all 2048 bitmap words to ones before the first beat.
// A new beat is taken once the previous result sits in the output register.

module bitmap_page_frame_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       operation,
  input  logic [15:0]                      frame_number,
  input  logic [16:0]                      frame_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [15:0]                      allocated_frame,
  output logic [16:0]                      used_count,
  output logic [16:0]                      free_count,
  input  logic                             cfg_write,
  input  logic [16:0]                      cfg_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                           state;
  bpfa_pkg::word_t                  bitmap [bpfa_pkg::WORD_COUNT];
  bpfa_pkg::word_t                  mem_q;
  logic [bpfa_pkg::ADDR_W-1:0]      addr;
  logic [bpfa_pkg::ADDR_W-1:0]      rd_word;
  logic                             issue_on;
  logic                             rd_pend;
  bpfa_pkg::span_t                  span;
  logic                             count_en;
  logic                             zero_rule;
  logic                             alloc_mode;
  logic [1:0]                       result_status;
  logic [bpfa_pkg::FRAME_W-1:0]     result_frame;
  logic [bpfa_pkg::COUNT_W-1:0]     used;
  logic [bpfa_pkg::COUNT_W-1:0]     total_frames;

  logic [bpfa_pkg::COUNT_W-1:0]     lim;
  logic [bpfa_pkg::COUNT_W:0]       region_end;
  logic [bpfa_pkg::COUNT_W:0]       add_sum;
  logic [bpfa_pkg::COUNT_W-1:0]     used_add;
  logic [bpfa_pkg::COUNT_W-1:0]     used_sub;
  logic [bpfa_pkg::COUNT_W-1:0]     used_inc;
  logic [bpfa_pkg::ADDR_W-1:0]      last_word;
  logic                             wr_en;
  logic [bpfa_pkg::ADDR_W-1:0]      wr_addr;
  bpfa_pkg::word_t                  wr_data;
  bpfa_pkg::word_res_t              res;

  bpfa_word_op u_word_op (
    .word      (mem_q),
    .word_addr (rd_word),
    .span      (span),
    .res       (res)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    lim        = (total_frames > bpfa_pkg::FRAME_LIMIT) ? bpfa_pkg::FRAME_LIMIT : total_frames;
    region_end = {2'b00, frame_number} + {1'b0, frame_count};
    last_word  = span.hi[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W];
    add_sum    = {1'b0, used} + (bpfa_pkg::COUNT_W + 1)'(res.flips);
    used_add   = (add_sum > {1'b0, bpfa_pkg::COUNT_MAX}) ? bpfa_pkg::COUNT_MAX
                                                         : add_sum[bpfa_pkg::COUNT_W-1:0];
    used_sub   = (used >= bpfa_pkg::COUNT_W'(res.flips))
                 ? used - bpfa_pkg::COUNT_W'(res.flips) : '0;
    used_inc   = (used == bpfa_pkg::COUNT_MAX) ? used : used + 1'b1;

    wr_en   = 1'b0;
    wr_addr = rd_word;
    wr_data = res.new_word;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = addr;
      wr_data = bpfa_pkg::ALL_ONES;
    end else if (state == ST_SWEEP && rd_pend) begin
      if (alloc_mode) begin
        wr_en   = res.found;
        wr_data = res.alloc_word;
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    mem_q   <= bitmap[addr];
    rd_word <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      addr         <= '0;
      issue_on     <= 1'b0;
      rd_pend      <= 1'b0;
      used         <= bpfa_pkg::FRAME_LIMIT;
      total_frames <= bpfa_pkg::FRAME_LIMIT;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        total_frames <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pend <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == bpfa_pkg::ADDR_W'(bpfa_pkg::WORD_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_valid) begin
            result_status <= bpfa_pkg::STATUS_OK;
            result_frame  <= '0;
            alloc_mode    <= 1'b0;
            count_en      <= 1'b1;
            zero_rule     <= 1'b0;
            issue_on      <= 1'b1;
            state         <= ST_SWEEP;
            unique case (operation)
              bpfa_pkg::OP_ALLOC: begin
                if (used >= lim) begin
                  result_status <= bpfa_pkg::STATUS_NOMEM;
                  state         <= ST_DONE;
                end else begin
                  alloc_mode    <= 1'b1;
                  span.lo       <= '0;
                  span.hi       <= bpfa_pkg::FRAME_W'(lim - 1'b1);
                  span.set_bits <= 1'b1;
                  addr          <= '0;
                end
              end
              bpfa_pkg::OP_FREE: begin
                if ({1'b0, frame_number} >= lim) begin
                  result_status <= bpfa_pkg::STATUS_RANGE;
                  state         <= ST_DONE;
                end else begin
                  span.lo       <= frame_number;
                  span.hi       <= frame_number;
                  span.set_bits <= 1'b0;
                  addr          <= frame_number[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W];
                end
              end
              bpfa_pkg::OP_RELEASE, bpfa_pkg::OP_RESERVE: begin
                if (region_end > {1'b0, lim}) begin
                  result_status <= bpfa_pkg::STATUS_RANGE;
                  state         <= ST_DONE;
                end else if (frame_count == '0) begin
                  span.lo       <= '0;
                  span.hi       <= '0;
                  span.set_bits <= 1'b1;
                  addr          <= '0;
                  if (lim == '0) begin
                    state <= ST_DONE;
                  end
                end else begin
                  zero_rule     <= 1'b1;
                  span.lo       <= frame_number;
                  span.hi       <= bpfa_pkg::FRAME_W'(region_end - 1'b1);
                  span.set_bits <= (operation == bpfa_pkg::OP_RESERVE);
                  addr          <= frame_number[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W];
                end
              end
              bpfa_pkg::OP_INIT: begin
                used          <= lim;
                count_en      <= 1'b0;
                span.lo       <= '0;
                span.hi       <= bpfa_pkg::FRAME_W'(lim - 1'b1);
                span.set_bits <= 1'b1;
                addr          <= '0;
                if (lim == '0) begin
                  state <= ST_DONE;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_SWEEP: begin
          if (issue_on) begin
            addr    <= addr + 1'b1;
            rd_pend <= 1'b1;
            if (addr == last_word) begin
              issue_on <= 1'b0;
            end
          end
          if (rd_pend) begin
            if (alloc_mode) begin
              if (res.found) begin
                used         <= used_inc;
                result_frame <= {rd_word, res.found_bit};
                issue_on     <= 1'b0;
                rd_pend      <= 1'b0;
                state        <= ST_DONE;
              end else if (rd_word == last_word) begin
                result_status <= bpfa_pkg::STATUS_NOMEM;
                issue_on      <= 1'b0;
                rd_pend       <= 1'b0;
                state         <= ST_DONE;
              end
            end else begin
              if (count_en) begin
                used <= span.set_bits ? used_add : used_sub;
              end
              if (rd_word == last_word) begin
                if (zero_rule) begin
                  zero_rule     <= 1'b0;
                  span.lo       <= '0;
                  span.hi       <= '0;
                  span.set_bits <= 1'b1;
                  addr          <= '0;
                  issue_on      <= 1'b1;
                  rd_pend       <= 1'b0;
                end else begin
                  state <= ST_DONE;
                end
              end
            end
          end
        end

        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= result_status;
            allocated_frame <= result_frame;
            used_count      <= used;
            free_count      <= (lim > used) ? lim - used : '0;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/bpfa_word_op.sv]
`timescale 1ns / 1ps

module bpfa_word_op (
  input  bpfa_pkg::word_t                   word,
  input  logic [bpfa_pkg::ADDR_W-1:0]       word_addr,
  input  bpfa_pkg::span_t                   span,
  output bpfa_pkg::word_res_t               res
);

  bpfa_pkg::word_t lo_mask;
  bpfa_pkg::word_t hi_mask;
  bpfa_pkg::word_t mask;
  bpfa_pkg::word_t free_bits;
  bpfa_pkg::word_t lowest;

  always_comb begin
    if (word_addr == span.lo[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W]) begin
      lo_mask = bpfa_pkg::ALL_ONES << span.lo[bpfa_pkg::BIT_W-1:0];
    end else begin
      lo_mask = bpfa_pkg::ALL_ONES;
    end
    if (word_addr == span.hi[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W]) begin
      hi_mask = bpfa_pkg::ALL_ONES >>
                (bpfa_pkg::BIT_W'(bpfa_pkg::WORD_BITS - 1) - span.hi[bpfa_pkg::BIT_W-1:0]);
    end else begin
      hi_mask = bpfa_pkg::ALL_ONES;
    end
    mask      = lo_mask & hi_mask;
    free_bits = ~word & mask;
    lowest    = free_bits & (~free_bits + bpfa_pkg::word_t'(1));

    res.new_word   = span.set_bits ? (word | mask) : (word & ~mask);
    res.flips      = bpfa_pkg::popcount(span.set_bits ? free_bits : (word & mask));
    res.found      = |free_bits;
    res.found_bit  = bpfa_pkg::bit_index(lowest);
    res.alloc_word = word | lowest;
  end

endmodule
